FILE: rtl/assert_macros.svh
// Assertion helper macros for the command stream parser checkers.
// Assumes clk and rst_n (synchronous, active low) exist in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of clk, off while in reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Same check, but also evaluated while reset is asserted.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

FILE: rtl/vgmcsp_pkg.sv
// Shared types, codes and helpers for the command stream parser.
// No dependencies; used by the top level and its checker.
`default_nettype none

package vgmcsp_pkg;

  // Result kinds
  localparam logic [2:0] KIND_WRITE  = 3'd0;
  localparam logic [2:0] KIND_PACKET = 3'd1;
  localparam logic [2:0] KIND_END    = 3'd2;
  localparam logic [2:0] KIND_LOOP   = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_CMD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_OFS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

  localparam logic [7:0]  RST_CHIP_CMD  = 8'd90;
  localparam logic [15:0] RST_THRESHOLD = 16'd50;

  // Stream commands
  localparam logic [7:0] CMD_END      = 8'h66;
  localparam logic [7:0] CMD_WAIT16   = 8'h61;
  localparam logic [7:0] CMD_WAIT_735 = 8'h62;
  localparam logic [7:0] CMD_WAIT_882 = 8'h63;
  localparam logic [7:0] CMD_BLOCK    = 8'h67;
  localparam logic [15:0] SAMPLES_735 = 16'd735;
  localparam logic [15:0] SAMPLES_882 = 16'd882;

  // Operand modes
  localparam logic [1:0] MODE_WAIT16 = 2'd0;
  localparam logic [1:0] MODE_CHIPW  = 2'd1;
  localparam logic [1:0] MODE_BLOCK  = 2'd2;
  localparam logic [1:0] MODE_SKIP   = 2'd3;

  // Operand positions
  localparam logic [2:0] OPIDX_IDLE   = 3'd0;
  localparam logic [2:0] OPIDX_FIRST  = 3'd1;
  localparam logic [2:0] OPIDX_SECOND = 3'd2;
  localparam logic [2:0] OPIDX_LEN_B0 = 3'd3;
  localparam logic [2:0] OPIDX_LEN_B1 = 3'd4;
  localparam logic [2:0] OPIDX_LEN_B2 = 3'd5;
  localparam logic [2:0] OPIDX_LEN_B3 = 3'd6;
  localparam logic [2:0] OPIDX_DATA   = 3'd7;

  localparam int RES_DEPTH = 4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_data;
    logic [15:0] wait_value;
    logic        last;
  } res_t;

  // max(total/2 - 1, 1), saturated to 16 bits
  function automatic logic [15:0] packet_wait(input logic [31:0] total);
    logic [30:0] half;
    logic [15:0] res;
    half = total[31:1];
    if (half <= 31'd1) begin
      res = 16'd1;
    end else if (half > 31'h10000) begin
      res = 16'hffff;
    end else begin
      res = 16'(half - 31'd1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/vgm_command_stream_parser.sv
// Command stream parser: one byte in, up to two results out, with a short result queue.
// Depends on vgmcsp_pkg.
// Takes one stream byte per cycle when not stalled. A byte accepted on in_* lands in an input
// register and is decoded once the result queue has at least two free entries; its results
// (zero, one or two) are pushed into a four-entry result queue that drives out_*; each result
// passes the input register and the queue registers before it shows on out_*. Throughput is one
// byte per cycle while each byte gives at most one result and the output is drained; a byte that
// gives two results (register write plus packet mark, or loop mark plus a command result) pushes
// both into the queue at once; the input register stalls whenever fewer than two queue entries are
// free. After an end mark or an unknown-command error, bytes are still taken but give no results
// until reset. cfg_ready is always high; write configuration only while no byte is in flight.
`default_nettype none

module vgm_command_stream_parser
  import vgmcsp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output      logic                 in_tready,
  input  wire logic [7:0]           in_tdata,   // [7:0] data_byte
  output      logic                 out_tvalid,
  input  wire logic                 out_tready,
  output      logic [31:0]          out_tdata,  // [7:0] reg_addr, [15:8] reg_data,
                                                // [31:16] wait_value
  output      logic [2:0]           out_tuser,  // [2:0] kind
  output      logic                 out_tlast,
  input  wire logic                 cfg_valid,
  output      logic                 cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int RES_QUEUE_DEPTH = RES_DEPTH;
  localparam int PTR_W = $clog2(RES_QUEUE_DEPTH);
  localparam int CNT_W = $clog2(RES_QUEUE_DEPTH + 1);

  // Configuration
  logic [7:0]  chip_command_r;
  logic        loop_enable_r;
  logic [31:0] loop_offset_r;
  logic [15:0] packet_threshold_r;

  // Input register
  logic        in_valid_r;
  logic [7:0]  in_byte_r;
  logic        proc_fire;

  // Parser state
  logic        finished_r,        finished_nxt;
  logic        loop_marked_r,     loop_marked_nxt;
  logic [7:0]  current_command_r, current_command_nxt;
  logic [1:0]  op_mode_r,         op_mode_nxt;
  logic [2:0]  operand_index_r,   operand_index_nxt;
  logic [31:0] skip_remaining_r,  skip_remaining_nxt;
  logic [31:0] block_length_r,    block_length_nxt;
  logic [31:0] wait_total_r,      wait_total_nxt;
  logic [31:0] byte_position_r,   byte_position_nxt;
  logic [7:0]  held_operand_r,    held_operand_nxt;

  logic [15:0] add_val;
  logic [31:0] sum;
  logic [31:0] blk_len;
  logic        do_complete;
  logic        is_write;
  logic        loop_v, main_v, pkt_v;
  res_t        main_res, pkt_res;
  res_t        r0, r1;
  logic        r0_v, r1_v;

  // Result queue
  res_t             res_mem [RES_QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] push_n;
  logic             pop;
  res_t             head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_command_r     <= RST_CHIP_CMD;
      loop_enable_r      <= 1'b0;
      loop_offset_r      <= '0;
      packet_threshold_r <= RST_THRESHOLD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CHIP_CMD:  chip_command_r     <= cfg_data[7:0];
        CFG_LOOP_EN:   loop_enable_r      <= cfg_data[0];
        CFG_LOOP_OFS:  loop_offset_r      <= cfg_data;
        CFG_THRESHOLD: packet_threshold_r <= cfg_data[15:0];
      endcase
    end
  end

  assign proc_fire = in_valid_r && (count_r <= CNT_W'(RES_QUEUE_DEPTH - 2));
  assign in_tready = !in_valid_r || proc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (proc_fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  always_comb begin
    finished_nxt        = finished_r;
    loop_marked_nxt     = loop_marked_r;
    current_command_nxt = current_command_r;
    op_mode_nxt         = op_mode_r;
    operand_index_nxt   = operand_index_r;
    skip_remaining_nxt  = skip_remaining_r;
    block_length_nxt    = block_length_r;
    wait_total_nxt      = wait_total_r;
    byte_position_nxt   = byte_position_r;
    held_operand_nxt    = held_operand_r;
    add_val     = '0;
    sum         = wait_total_r;
    blk_len     = block_length_r;
    do_complete = 1'b0;
    is_write    = 1'b0;
    loop_v      = 1'b0;
    main_v      = 1'b0;
    pkt_v       = 1'b0;
    main_res    = '0;
    pkt_res     = '0;

    if (proc_fire && !finished_r) begin
      byte_position_nxt = byte_position_r + 32'd1;
      if (operand_index_r == OPIDX_IDLE) begin
        if (loop_enable_r && !loop_marked_r && (byte_position_r >= loop_offset_r)) begin
          loop_v          = 1'b1;
          loop_marked_nxt = 1'b1;
        end
        priority if (in_byte_r == CMD_END) begin
          main_v              = 1'b1;
          main_res.kind       = KIND_END;
          main_res.wait_value = packet_wait(wait_total_r);
          wait_total_nxt      = '0;
          finished_nxt        = 1'b1;
        end else if (in_byte_r == CMD_WAIT16) begin
          current_command_nxt = in_byte_r;
          op_mode_nxt         = MODE_WAIT16;
          operand_index_nxt   = OPIDX_FIRST;
        end else if (in_byte_r[7:4] == 4'h7) begin
          add_val     = 16'(in_byte_r[3:0]) + 16'd1;
          do_complete = 1'b1;
        end else if (in_byte_r == CMD_WAIT_735) begin
          add_val     = SAMPLES_735;
          do_complete = 1'b1;
        end else if (in_byte_r == CMD_WAIT_882) begin
          add_val     = SAMPLES_882;
          do_complete = 1'b1;
        end else if (in_byte_r == chip_command_r) begin
          current_command_nxt = in_byte_r;
          op_mode_nxt         = MODE_CHIPW;
          operand_index_nxt   = OPIDX_FIRST;
        end else if (in_byte_r == CMD_BLOCK) begin
          current_command_nxt = in_byte_r;
          op_mode_nxt         = MODE_BLOCK;
          block_length_nxt    = '0;
          operand_index_nxt   = OPIDX_FIRST;
        end else if (in_byte_r[7:4] == 4'h8) begin
          add_val     = 16'(in_byte_r[3:0]);
          do_complete = 1'b1;
        end else if (in_byte_r[7:4] == 4'h3) begin
          current_command_nxt = in_byte_r;
          op_mode_nxt         = MODE_SKIP;
          skip_remaining_nxt  = 32'd1;
          operand_index_nxt   = OPIDX_FIRST;
        end else if ((in_byte_r[7:5] == 3'b010) || (in_byte_r[7:5] == 3'b101)) begin
          current_command_nxt = in_byte_r;
          op_mode_nxt         = MODE_SKIP;
          skip_remaining_nxt  = 32'd2;
          operand_index_nxt   = OPIDX_FIRST;
        end else if (in_byte_r[7:5] == 3'b110) begin
          current_command_nxt = in_byte_r;
          op_mode_nxt         = MODE_SKIP;
          skip_remaining_nxt  = 32'd3;
          operand_index_nxt   = OPIDX_FIRST;
        end else if (in_byte_r[7:5] == 3'b111) begin
          current_command_nxt = in_byte_r;
          op_mode_nxt         = MODE_SKIP;
          skip_remaining_nxt  = 32'd4;
          operand_index_nxt   = OPIDX_FIRST;
        end else begin
          main_v        = 1'b1;
          main_res.kind = KIND_ERROR;
          finished_nxt  = 1'b1;
        end
      end else begin
        unique case (op_mode_r)
          MODE_WAIT16: begin
            if (operand_index_r == OPIDX_FIRST) begin
              held_operand_nxt  = in_byte_r;
              operand_index_nxt = OPIDX_SECOND;
            end else begin
              add_val     = {in_byte_r, held_operand_r};
              do_complete = 1'b1;
            end
          end
          MODE_CHIPW: begin
            if (operand_index_r == OPIDX_FIRST) begin
              held_operand_nxt  = in_byte_r;
              operand_index_nxt = OPIDX_SECOND;
            end else begin
              is_write          = 1'b1;
              main_v            = 1'b1;
              main_res.kind     = KIND_WRITE;
              main_res.reg_addr = held_operand_r;
              main_res.reg_data = in_byte_r;
              do_complete       = 1'b1;
            end
          end
          MODE_BLOCK: begin
            if (operand_index_r != OPIDX_DATA) begin
              unique case (operand_index_r)
                OPIDX_LEN_B0: blk_len[7:0]   = blk_len[7:0]   | in_byte_r;
                OPIDX_LEN_B1: blk_len[15:8]  = blk_len[15:8]  | in_byte_r;
                OPIDX_LEN_B2: blk_len[23:16] = blk_len[23:16] | in_byte_r;
                OPIDX_LEN_B3: blk_len[31:24] = blk_len[31:24] | in_byte_r;
                default: ;
              endcase
              block_length_nxt = blk_len;
              if (operand_index_r == OPIDX_LEN_B3) begin
                if (blk_len == '0) begin
                  do_complete = 1'b1;
                end else begin
                  skip_remaining_nxt = blk_len;
                  operand_index_nxt  = OPIDX_DATA;
                end
              end else begin
                operand_index_nxt = operand_index_r + 3'd1;
              end
            end else if (skip_remaining_r <= 32'd1) begin
              do_complete = 1'b1;
            end else begin
              skip_remaining_nxt = skip_remaining_r - 32'd1;
            end
          end
          MODE_SKIP: begin
            if (skip_remaining_r <= 32'd1) begin
              do_complete = 1'b1;
            end else begin
              skip_remaining_nxt = skip_remaining_r - 32'd1;
            end
          end
        endcase
      end

      sum = wait_total_r + 32'(add_val);
      if (do_complete) begin
        operand_index_nxt  = OPIDX_IDLE;
        skip_remaining_nxt = '0;
        if (sum >= 32'(packet_threshold_r)) begin
          wait_total_nxt = '0;
          if (is_write) begin
            pkt_v              = 1'b1;
            pkt_res.kind       = KIND_PACKET;
            pkt_res.wait_value = packet_wait(sum);
          end else begin
            main_v              = 1'b1;
            main_res.kind       = KIND_PACKET;
            main_res.wait_value = packet_wait(sum);
          end
        end else begin
          wait_total_nxt = sum;
        end
      end
    end
  end

  always_comb begin
    r0      = '0;
    r1      = '0;
    r0_v    = loop_v || main_v;
    r1_v    = loop_v ? main_v : pkt_v;
    if (loop_v) begin
      r0.kind = KIND_LOOP;
      r1      = main_res;
    end else begin
      r0 = main_res;
      r1 = pkt_res;
    end
    r0.last = !r1_v;
    r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      finished_r        <= 1'b0;
      loop_marked_r     <= 1'b0;
      current_command_r <= '0;
      op_mode_r         <= MODE_WAIT16;
      operand_index_r   <= OPIDX_IDLE;
      skip_remaining_r  <= '0;
      block_length_r    <= '0;
      wait_total_r      <= '0;
      byte_position_r   <= '0;
      held_operand_r    <= '0;
    end else begin
      finished_r        <= finished_nxt;
      loop_marked_r     <= loop_marked_nxt;
      current_command_r <= current_command_nxt;
      op_mode_r         <= op_mode_nxt;
      operand_index_r   <= operand_index_nxt;
      skip_remaining_r  <= skip_remaining_nxt;
      block_length_r    <= block_length_nxt;
      wait_total_r      <= wait_total_nxt;
      byte_position_r   <= byte_position_nxt;
      held_operand_r    <= held_operand_nxt;
    end
  end

  // Result queue
  assign push_n = CNT_W'(r0_v) + CNT_W'(r1_v);
  assign pop    = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (r0_v) begin
      res_mem[wr_ptr_r] <= r0;
    end
    if (r1_v) begin
      res_mem[wr_ptr_r + PTR_W'(1)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(pop);
      count_r  <= count_r + push_n - CNT_W'(pop);
    end
  end

  assign head       = res_mem[rd_ptr_r];
  assign out_tvalid = (count_r != '0);
  assign out_tdata  = {head.wait_value, head.reg_data, head.reg_addr};
  assign out_tuser  = head.kind;
  assign out_tlast  = head.last;

endmodule

`default_nettype wire

FILE: rtl/vgmcsp_checker.sv
// Port-level checks on the result channel of the command stream parser, and its bind.
// Depends on vgmcsp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module vgmcsp_checker
  import vgmcsp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [2:0]  out_tuser,
  input wire logic        out_tlast
);

  `ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result transaction changed")
  `ASSERT_CLK(a_kind_range, out_tvalid |-> out_tuser <= KIND_ERROR, "result kind out of range")
  `ASSERT_CLK(a_nonwrite_zero, out_tvalid && out_tuser != KIND_WRITE |-> out_tdata[15:0] == 16'd0, "address or data set on a mark")
  `ASSERT_CLK(a_wait_nonzero, out_tvalid && (out_tuser == KIND_PACKET || out_tuser == KIND_END) |-> out_tdata[31:16] != 16'd0, "packet or end mark with zero wait")

endmodule

bind vgm_command_stream_parser vgmcsp_checker u_vgmcsp_checker (.*);

`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for vgm_command_stream_parser: streams command bytes, predicts
// register writes, packet, end, loop and error marks, and compares every output transaction.
// Depends on vgmcsp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module testbench
  import vgmcsp_pkg::*;
();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 12;

  // Command byte ranges
  localparam logic [7:0] CMD_SHORT_LO  = 8'h70;
  localparam logic [7:0] CMD_SHORT_HI  = 8'h7f;
  localparam logic [7:0] CMD_WAITN_LO  = 8'h80;
  localparam logic [7:0] CMD_WAITN_HI  = 8'h8f;
  localparam logic [7:0] CMD_SKIP1_LO  = 8'h30;
  localparam logic [7:0] CMD_SKIP2_LO  = 8'h40;
  localparam logic [7:0] CMD_SKIP2_END = 8'h60;
  localparam logic [7:0] CMD_SKIP2B_LO = 8'ha0;
  localparam logic [7:0] CMD_SKIP3_LO  = 8'hc0;
  localparam logic [7:0] CMD_SKIP4_LO  = 8'he0;

  typedef enum {
    CL_END, CL_WAIT16, CL_SHORT, CL_735, CL_882, CL_CHIP, CL_BLOCK, CL_WAITN,
    CL_SKIP1, CL_SKIP2, CL_SKIP3, CL_SKIP4, CL_UNKNOWN
  } cmd_class_e;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [7:0] data_byte
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;  // [7:0] reg_addr, [15:8] reg_data, [31:16] wait_value
  logic [2:0]           out_tuser;  // [2:0] kind
  logic                 out_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  vgm_command_stream_parser uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow configuration
  logic [7:0]  cf_chip;
  logic        cf_loop_en;
  logic [31:0] cf_loop_ofs;
  logic [15:0] cf_thresh;

  // Shadow parser state
  logic        st_done;
  logic        st_looped;
  logic [2:0]  st_opidx;
  logic [1:0]  st_mode;
  logic [31:0] st_skip;
  logic [31:0] st_blen;
  logic [31:0] st_waits;
  logic [31:0] st_pos;
  logic [7:0]  st_hold;

  res_t expected_results[$];
  res_t byte_res[0:1];
  int   n_res;
  res_t head;

  int errors;
  int cycle_count;
  int sent_items;
  int burst_left;
  bit no_gaps;
  int hold_req;
  int hold_left;
  int rx_tick;
  int rx_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: stall pattern is re-picked at random from four modes; long hold-offs on request
  always @(negedge clk) begin
    rx_tick++;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (rx_tick % 50 == 0) rx_mode = $urandom_range(0, 3);
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (rx_tick % 4 == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  task automatic check_field(input string fname, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0h, got %0h", fname, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected transaction: kind %0d data %0h", out_tuser, out_tdata);
        errors++;
      end else begin
        head = expected_results.pop_front();
        check_field("kind", head.kind, out_tuser);
        check_field("reg_addr", head.reg_addr, out_tdata[7:0]);
        check_field("reg_data", head.reg_data, out_tdata[15:8]);
        check_field("wait_value", head.wait_value, out_tdata[31:16]);
        check_field("last", head.last, out_tlast);
      end
    end
  end

  // ---------------- prediction ----------------

  function automatic cmd_class_e cmd_class(input logic [7:0] b);
    if (b == CMD_END) return CL_END;
    if (b == CMD_WAIT16) return CL_WAIT16;
    if (b >= CMD_SHORT_LO && b <= CMD_SHORT_HI) return CL_SHORT;
    if (b == CMD_WAIT_735) return CL_735;
    if (b == CMD_WAIT_882) return CL_882;
    if (b == cf_chip) return CL_CHIP;
    if (b == CMD_BLOCK) return CL_BLOCK;
    if (b >= CMD_WAITN_LO && b <= CMD_WAITN_HI) return CL_WAITN;
    if (b >= CMD_SKIP1_LO && b < CMD_SKIP2_LO) return CL_SKIP1;
    if ((b >= CMD_SKIP2_LO && b < CMD_SKIP2_END) || (b >= CMD_SKIP2B_LO && b < CMD_SKIP3_LO))
      return CL_SKIP2;
    if (b >= CMD_SKIP3_LO && b < CMD_SKIP4_LO) return CL_SKIP3;
    if (b >= CMD_SKIP4_LO) return CL_SKIP4;
    return CL_UNKNOWN;
  endfunction

  // half the total minus one, floor 1, capped at 16 bits
  function automatic logic [15:0] halved_wait(input logic [31:0] total);
    logic [31:0] half;
    half = total >> 1;
    if (half <= 32'd1) return 16'd1;
    half = half - 32'd1;
    if (half > 32'h0000_ffff) return 16'hffff;
    return half[15:0];
  endfunction

  task automatic add_result(input logic [2:0] kind, input logic [7:0] a, input logic [7:0] d,
                            input logic [15:0] w);
    byte_res[n_res] = '{kind, a, d, w, 1'b0};
    n_res++;
  endtask

  task automatic close_command();
    st_opidx = OPIDX_IDLE;
    st_skip  = 32'd0;
    if (st_waits >= {16'd0, cf_thresh}) begin
      add_result(KIND_PACKET, 8'd0, 8'd0, halved_wait(st_waits));
      st_waits = 32'd0;
    end
  endtask

  task automatic begin_skip(input int count);
    st_mode  = MODE_SKIP;
    st_skip  = count;
    st_opidx = OPIDX_FIRST;
  endtask

  task automatic decode_stream_byte(input logic [7:0] b);
    logic [31:0] at;
    n_res = 0;
    if (!st_done) begin
      at     = st_pos;
      st_pos = st_pos + 32'd1;
      if (st_opidx == OPIDX_IDLE) begin
        if (cf_loop_en && !st_looped && at >= cf_loop_ofs) begin
          add_result(KIND_LOOP, 8'd0, 8'd0, 16'd0);
          st_looped = 1'b1;
        end
        case (cmd_class(b))
          CL_END: begin
            add_result(KIND_END, 8'd0, 8'd0, halved_wait(st_waits));
            st_waits = 32'd0;
            st_done  = 1'b1;
          end
          CL_WAIT16: begin
            st_mode  = MODE_WAIT16;
            st_opidx = OPIDX_FIRST;
          end
          CL_SHORT: begin
            st_waits = st_waits + b[3:0] + 32'd1;
            close_command();
          end
          CL_735: begin
            st_waits = st_waits + SAMPLES_735;
            close_command();
          end
          CL_882: begin
            st_waits = st_waits + SAMPLES_882;
            close_command();
          end
          CL_CHIP: begin
            st_mode  = MODE_CHIPW;
            st_opidx = OPIDX_FIRST;
          end
          CL_BLOCK: begin
            st_mode  = MODE_BLOCK;
            st_blen  = 32'd0;
            st_opidx = OPIDX_FIRST;
          end
          CL_WAITN: begin
            st_waits = st_waits + b[3:0];
            close_command();
          end
          CL_SKIP1: begin_skip(1);
          CL_SKIP2: begin_skip(2);
          CL_SKIP3: begin_skip(3);
          CL_SKIP4: begin_skip(4);
          default: begin
            add_result(KIND_ERROR, 8'd0, 8'd0, 16'd0);
            st_done = 1'b1;
          end
        endcase
      end else if (st_mode == MODE_WAIT16 || st_mode == MODE_CHIPW) begin
        if (st_opidx == OPIDX_FIRST) begin
          st_hold  = b;
          st_opidx = OPIDX_SECOND;
        end else begin
          if (st_mode == MODE_CHIPW) add_result(KIND_WRITE, st_hold, b, 16'd0);
          else st_waits = st_waits + {16'd0, b, st_hold};
          close_command();
        end
      end else if (st_mode == MODE_BLOCK) begin
        if (st_opidx != OPIDX_DATA) begin
          if (st_opidx >= OPIDX_LEN_B0)
            st_blen = st_blen | ({24'd0, b} << (8 * (st_opidx - OPIDX_LEN_B0)));
          if (st_opidx == OPIDX_LEN_B3) begin
            if (st_blen == 32'd0) begin
              close_command();
            end else begin
              st_skip  = st_blen;
              st_opidx = OPIDX_DATA;
            end
          end else begin
            st_opidx = st_opidx + 3'd1;
          end
        end else begin
          st_skip = st_skip - 32'd1;
          if (st_skip == 32'd0) close_command();
        end
      end else begin
        if (st_skip > 32'd0) st_skip = st_skip - 32'd1;
        if (st_skip == 32'd0) close_command();
      end
    end
    if (n_res > 0) byte_res[n_res-1].last = 1'b1;
    for (int i = 0; i < n_res; i++) expected_results.push_back(byte_res[i]);
  endtask

  // ---------------- drivers ----------------

  // Entered and left at a falling edge; tvalid stays up between back-to-back bytes.
  task automatic send_byte(input logic [7:0] b);
    if (!no_gaps && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_stream_byte(b);
    sent_items++;
    if (burst_left > 0) burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_CHIP_CMD:  cf_chip = val[7:0];
      CFG_LOOP_EN:   cf_loop_en = val[0];
      CFG_LOOP_OFS:  cf_loop_ofs = val;
      CFG_THRESHOLD: cf_thresh = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // One well-formed command with random operands; never an end or unknown byte.
  task automatic send_command();
    logic [7:0] c;
    cmd_class_e k;
    int pick;
    int len;
    pick = $urandom_range(0, 9);
    if (pick < 4 && cmd_class(cf_chip) == CL_CHIP) begin
      c = cf_chip;
    end else if (pick == 4) begin
      c = CMD_BLOCK;
    end else begin
      do c = 8'($urandom); while (cmd_class(c) == CL_END || cmd_class(c) == CL_UNKNOWN);
    end
    k = cmd_class(c);
    send_byte(c);
    if (k == CL_BLOCK) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      send_byte(8'($urandom));
      send_byte(8'($urandom));
      send_byte(8'(len));
      repeat (3) send_byte(8'h00);
      repeat (len) send_byte(8'($urandom));
    end else if (k == CL_WAIT16) begin
      send_byte(8'($urandom));
      send_byte($urandom_range(0, 1) ? 8'($urandom) : 8'h00);
    end else begin
      while (st_opidx != OPIDX_IDLE && !st_done) send_byte(8'($urandom));
    end
  endtask

  // ---------------- tests ----------------

  task automatic test_command_set();
    logic [7:0] seq[$];
    seq = '{RST_CHIP_CMD, 8'h00, 8'hff, RST_CHIP_CMD, 8'hff, 8'h00,
            CMD_SHORT_HI, CMD_WAITN_LO, CMD_WAITN_HI,
            CMD_WAIT16, 8'h13, 8'h00,
            CMD_WAIT_735, CMD_WAIT_882,
            CMD_BLOCK, 8'h00, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00,
            CMD_BLOCK, 8'haa, 8'h55, 8'h02, 8'h00, 8'h00, 8'h00, 8'hde, 8'had,
            CMD_SKIP4_LO, 8'h01, 8'h02, 8'h04, 8'h08, CMD_SKIP1_LO, 8'h80};
    foreach (seq[i]) send_byte(seq[i]);
    wait_results_done();
  endtask

  task automatic test_config_registers();
    write_reg(CFG_CHIP_CMD, 32'h00);
    send_byte(8'h00); send_byte(8'h12); send_byte(8'h34);
    wait_results_done();
    write_reg(CFG_CHIP_CMD, 32'hff);
    send_byte(8'hff); send_byte(8'hab); send_byte(8'hcd);
    wait_results_done();
    // shadowed: decodes as a 16-bit wait
    write_reg(CFG_CHIP_CMD, {24'd0, CMD_WAIT16});
    send_byte(CMD_WAIT16); send_byte(8'h05); send_byte(8'h00);
    wait_results_done();
    write_reg(CFG_THRESHOLD, 32'd1);
    send_byte(CMD_WAITN_LO); send_byte(CMD_SHORT_LO); send_byte(CMD_WAITN_LO);
    wait_results_done();
    // register change in the middle of a write keeps the write
    write_reg(CFG_CHIP_CMD, {24'd0, CMD_SKIP2_LO});
    send_byte(CMD_SKIP2_LO);
    wait_results_done();
    write_reg(CFG_CHIP_CMD, {24'd0, RST_CHIP_CMD});
    write_reg(CFG_THRESHOLD, 32'd65535);
    send_byte(8'h77); send_byte(8'h88);
    send_byte(CMD_WAIT_735); send_byte(CMD_WAIT_882);
    wait_results_done();
    write_reg(CFG_THRESHOLD, {16'd0, RST_THRESHOLD});
  endtask

  task automatic test_loop_mark();
    write_reg(CFG_LOOP_OFS, 32'hffff_ffff);
    write_reg(CFG_LOOP_EN, 32'd1);
    repeat (6) send_command();
    wait_results_done();
    write_reg(CFG_THRESHOLD, 32'd1);
    write_reg(CFG_LOOP_OFS, st_pos + 32'd3);
    repeat (8) send_command();
    wait_results_done();
    // already marked once
    write_reg(CFG_LOOP_OFS, 32'd0);
    repeat (4) send_command();
    wait_results_done();
    write_reg(CFG_LOOP_EN, 32'd0);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_THRESHOLD, 32'd1);
    no_gaps  = 1'b1;
    hold_req = 300;
    repeat (40) send_command();
    no_gaps = 1'b0;
    wait_results_done();
  endtask

  task automatic test_random_stream();
    int phase_end;
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 3))
        0: write_reg(CFG_CHIP_CMD, {24'd0, RST_CHIP_CMD});
        1: write_reg(CFG_CHIP_CMD, 32'h00);
        2: write_reg(CFG_CHIP_CMD, 32'hff);
        default: write_reg(CFG_CHIP_CMD, $urandom_range(0, 255));
      endcase
      case (ph % 4)
        0: write_reg(CFG_THRESHOLD, 32'd1);
        1: write_reg(CFG_THRESHOLD, 32'd65535);
        2: write_reg(CFG_THRESHOLD, $urandom_range(1, 100));
        default: write_reg(CFG_THRESHOLD, $urandom_range(1, 4000));
      endcase
      write_reg(CFG_LOOP_EN, $urandom_range(0, 1));
      write_reg(CFG_LOOP_OFS, $urandom);
      phase_end = sent_items + 65;
      while (sent_items < phase_end) send_command();
      wait_results_done();
    end
  endtask

  task automatic test_stop();
    logic [7:0] b;
    write_reg(CFG_CHIP_CMD, {24'd0, RST_CHIP_CMD});
    write_reg(CFG_THRESHOLD, 32'd65535);
    send_byte(CMD_WAIT_882);
    send_byte(CMD_WAIT16); send_byte(8'h34); send_byte(8'h12);
    // only one stop per reset: end mark or unknown command, chosen per seed
    if ($urandom_range(0, 1) == 1) b = CMD_END;
    else do b = 8'($urandom); while (cmd_class(b) != CL_UNKNOWN);
    send_byte(b);
    repeat (20) send_byte(8'($urandom));
    wait_results_done();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'd0;
    out_tready  = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_CHIP_CMD;
    cfg_data    = 32'd0;
    cf_chip     = RST_CHIP_CMD;
    cf_loop_en  = 1'b0;
    cf_loop_ofs = 32'd0;
    cf_thresh   = RST_THRESHOLD;
    st_done     = 1'b0;
    st_looped   = 1'b0;
    st_opidx    = OPIDX_IDLE;
    st_mode     = MODE_WAIT16;
    st_skip     = 32'd0;
    st_blen     = 32'd0;
    st_waits    = 32'd0;
    st_pos      = 32'd0;
    st_hold     = 8'd0;
    errors      = 0;
    cycle_count = 0;
    sent_items  = 0;
    burst_left  = 0;
    no_gaps     = 1'b0;
    hold_req    = 0;
    hold_left   = 0;
    rx_tick     = 0;
    rx_mode     = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_command_set();
    test_config_registers();
    test_loop_mark();
    test_backpressure();
    test_random_stream();
    test_stop();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/vgmcsp_pkg.sv
rtl/vgm_command_stream_parser.sv
rtl/vgmcsp_checker.sv
dv/testbench.sv
